// ===== design/rfa_pkg.sv =====
// ----------------------------------------------------------------------------
// rfa_pkg: shared types and constants for the rational fraction ALU
// Word layouts, operation codes, sequencer states and operand helpers.
// ----------------------------------------------------------------------------
package rfa_pkg;

	// Field widths
	localparam int OPERAND_WIDTH = 16;
	localparam int NUM_W = OPERAND_WIDTH;       // numerator, two's complement
	localparam int DEN_W = OPERAND_WIDTH - 1;   // denominator, unsigned
	localparam int RES_W = 32;                  // result fields
	localparam int MUL_W = NUM_W + 1;           // signed multiplier operand

	// Operation codes
	typedef enum logic [1:0] {
		OP_MUL = 2'd0,
		OP_DIV = 2'd1,
		OP_ADD = 2'd2,
		OP_SUB = 2'd3
	} op_t;

	// Input word
	typedef struct packed {
		op_t                     req_type;
		logic signed [NUM_W-1:0] a_num;
		logic        [DEN_W-1:0] a_den;
		logic signed [NUM_W-1:0] b_num;
		logic        [DEN_W-1:0] b_den;
	} req_t;

	// Result word
	typedef struct packed {
		logic signed [RES_W-1:0] res_num;
		logic signed [RES_W-1:0] res_den;
		logic                    error;
	} rsp_t;

	// Divider status back to the sequencer
	typedef struct packed {
		logic             done;
		logic [DEN_W-1:0] quot;
		logic [DEN_W-1:0] rem;
	} div_res_t;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_P1,
		ST_P2,
		ST_P3,
		ST_GCD_STEP,
		ST_GCD_RUN,
		ST_QA_STEP,
		ST_QA_RUN,
		ST_QB_STEP,
		ST_QB_RUN,
		ST_LCM,
		ST_TA,
		ST_TB,
		ST_SUM
	} st_t;

	// Sign-extend a numerator to a multiplier operand
	function automatic logic signed [MUL_W-1:0] sext_num(input logic signed [NUM_W-1:0] v);
		sext_num = {v[NUM_W-1], v};
	endfunction

	// Zero-extend a denominator or quotient to a multiplier operand
	function automatic logic signed [MUL_W-1:0] zext_den(input logic [DEN_W-1:0] v);
		zext_den = {2'b00, v};
	endfunction

endpackage

// ===== design/rfa_divider.sv =====
// ----------------------------------------------------------------------------
// rfa_divider: iterative unsigned divider
// Restoring division, one quotient bit per cycle; operands taken at start.
// ----------------------------------------------------------------------------
module rfa_divider (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [rfa_pkg::DEN_W-1:0] dividend,
	input  logic [rfa_pkg::DEN_W-1:0] divisor,
	output rfa_pkg::div_res_t         res
);
	localparam int DW    = rfa_pkg::DEN_W;
	localparam int CNT_W = $clog2(DW + 1);

	logic [DW-1:0]    rem_q;
	logic [DW-1:0]    quo_q;
	logic [DW-1:0]    dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic             done_q;

	logic [DW:0]   shifted;
	logic          fits;
	logic [DW:0]   diff;
	logic [DW-1:0] rem_next;

	// One trial subtraction per cycle
	always_comb begin
		shifted  = {rem_q, quo_q[DW-1]};
		fits     = shifted >= {1'b0, dvs_q};
		diff     = shifted - {1'b0, dvs_q};
		rem_next = fits ? diff[DW-1:0] : shifted[DW-1:0];
	end

	// Iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(DW);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Partial remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (run_q) begin
			rem_q <= rem_next;
			quo_q <= {quo_q[DW-2:0], fits};
		end
	end

	assign res.done = done_q;
	assign res.quot = quo_q;
	assign res.rem  = rem_q;

endmodule

// ===== design/rfa_mult.sv =====
// ----------------------------------------------------------------------------
// rfa_mult: shared signed multiplier
// Signed product of two operands, registered, low result bits kept.
// ----------------------------------------------------------------------------
module rfa_mult (
	input  logic                             clk,
	input  logic signed [rfa_pkg::MUL_W-1:0] op_a,
	input  logic signed [rfa_pkg::MUL_W-1:0] op_b,
	output logic signed [rfa_pkg::RES_W-1:0] prod
);
	logic signed [2*rfa_pkg::MUL_W-1:0] full;
	logic signed [rfa_pkg::RES_W-1:0]   prod_q;

	// Full-width product, wrapped to the result width
	assign full = op_a * op_b;

	always_ff @(posedge clk) begin
		prod_q <= full[rfa_pkg::RES_W-1:0];
	end

	assign prod = prod_q;

endmodule

// ===== design/rational_fraction_alu_core.sv =====
// ----------------------------------------------------------------------------
// rational_fraction_alu_core: fraction multiply, divide, add and subtract
// Multiply/divide: check, two products (P1, P2) and the result in P3; a zero
// denominator or a zero divisor ends in the check with an error word.
// Add/subtract: Euclid steps on the divider, two quotient passes, then the
// LCM, the two scaled numerators and the sum.
// One word at a time: busy stays high until the sequencer returns to idle.
// Reset clears the sequencer and the done strobe; the receiver cannot stall.
// ----------------------------------------------------------------------------
module rational_fraction_alu_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  rfa_pkg::req_t     cmd,
	output logic              done,
	output rfa_pkg::rsp_t     result
);
	rfa_pkg::st_t      state_q, state_d;
	rfa_pkg::req_t     req_q;
	rfa_pkg::rsp_t     res_q;
	logic              done_q;

	logic [rfa_pkg::DEN_W-1:0] x_q, y_q;
	logic [rfa_pkg::DEN_W-1:0] qa_q, qb_q;
	logic signed [rfa_pkg::RES_W-1:0] num_q, den_q;

	logic                             div_start;
	rfa_pkg::div_res_t                div_res;
	logic signed [rfa_pkg::MUL_W-1:0] mul_a, mul_b;
	logic signed [rfa_pkg::RES_W-1:0] prod;
	logic                             bad_in;
	logic                             is_mul;

	// Shared units
	rfa_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (x_q),
		.divisor  (y_q),
		.res      (div_res)
	);

	rfa_mult u_mul (
		.clk  (clk),
		.op_a (mul_a),
		.op_b (mul_b),
		.prod (prod)
	);

	// Operand checks on the latched word
	assign bad_in = (req_q.a_den == '0) || (req_q.b_den == '0) ||
		((req_q.req_type == rfa_pkg::OP_DIV) && (req_q.b_num == '0));
	assign is_mul = (req_q.req_type == rfa_pkg::OP_MUL);

	// Sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rfa_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, divider start and multiplier operands
	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		case (state_q)
			rfa_pkg::ST_IDLE: begin
				if (start) state_d = rfa_pkg::ST_CHECK;
			end
			rfa_pkg::ST_CHECK: begin
				if (bad_in) state_d = rfa_pkg::ST_IDLE;
				else if (req_q.req_type == rfa_pkg::OP_MUL ||
					req_q.req_type == rfa_pkg::OP_DIV) state_d = rfa_pkg::ST_P1;
				else state_d = rfa_pkg::ST_GCD_STEP;
			end
			rfa_pkg::ST_P1: begin
				mul_a   = rfa_pkg::sext_num(req_q.a_num);
				mul_b   = is_mul ? rfa_pkg::sext_num(req_q.b_num)
					: rfa_pkg::zext_den(req_q.b_den);
				state_d = rfa_pkg::ST_P2;
			end
			rfa_pkg::ST_P2: begin
				mul_a   = rfa_pkg::zext_den(req_q.a_den);
				mul_b   = is_mul ? rfa_pkg::zext_den(req_q.b_den)
					: rfa_pkg::sext_num(req_q.b_num);
				state_d = rfa_pkg::ST_P3;
			end
			rfa_pkg::ST_P3: begin
				state_d = rfa_pkg::ST_IDLE;
			end
			rfa_pkg::ST_GCD_STEP: begin
				div_start = 1'b1;
				state_d   = rfa_pkg::ST_GCD_RUN;
			end
			rfa_pkg::ST_GCD_RUN: begin
				if (div_res.done) begin
					state_d = (div_res.rem == '0) ? rfa_pkg::ST_QA_STEP
						: rfa_pkg::ST_GCD_STEP;
				end
			end
			rfa_pkg::ST_QA_STEP: begin
				div_start = 1'b1;
				state_d   = rfa_pkg::ST_QA_RUN;
			end
			rfa_pkg::ST_QA_RUN: begin
				if (div_res.done) state_d = rfa_pkg::ST_QB_STEP;
			end
			rfa_pkg::ST_QB_STEP: begin
				div_start = 1'b1;
				state_d   = rfa_pkg::ST_QB_RUN;
			end
			rfa_pkg::ST_QB_RUN: begin
				if (div_res.done) state_d = rfa_pkg::ST_LCM;
			end
			rfa_pkg::ST_LCM: begin
				mul_a   = rfa_pkg::zext_den(req_q.a_den);
				mul_b   = rfa_pkg::zext_den(qa_q);
				state_d = rfa_pkg::ST_TA;
			end
			rfa_pkg::ST_TA: begin
				mul_a   = rfa_pkg::sext_num(req_q.a_num);
				mul_b   = rfa_pkg::zext_den(qa_q);
				state_d = rfa_pkg::ST_TB;
			end
			rfa_pkg::ST_TB: begin
				mul_a   = rfa_pkg::sext_num(req_q.b_num);
				mul_b   = rfa_pkg::zext_den(qb_q);
				state_d = rfa_pkg::ST_SUM;
			end
			rfa_pkg::ST_SUM: begin
				state_d = rfa_pkg::ST_IDLE;
			end
			default: begin
				state_d = rfa_pkg::ST_IDLE;
			end
		endcase
	end

	// Done strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (state_q == rfa_pkg::ST_CHECK && bad_in) ||
				state_q == rfa_pkg::ST_P3 || state_q == rfa_pkg::ST_SUM;
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			rfa_pkg::ST_IDLE: begin
				if (start) req_q <= cmd;
			end
			rfa_pkg::ST_CHECK: begin
				x_q <= req_q.a_den;
				y_q <= req_q.b_den;
				if (bad_in) begin
					res_q.res_num <= '0;
					res_q.res_den <= '0;
					res_q.error   <= 1'b1;
				end
			end
			rfa_pkg::ST_P2: begin
				num_q <= prod;
			end
			rfa_pkg::ST_P3: begin
				res_q.res_num <= num_q;
				res_q.res_den <= prod;
				res_q.error   <= 1'b0;
			end
			// Euclid step: (x, y) <- (y, x mod y); gcd stays in y
			rfa_pkg::ST_GCD_RUN: begin
				if (div_res.done) begin
					if (div_res.rem == '0) begin
						x_q <= req_q.b_den;
					end else begin
						x_q <= y_q;
						y_q <= div_res.rem;
					end
				end
			end
			rfa_pkg::ST_QA_RUN: begin
				if (div_res.done) begin
					qa_q <= div_res.quot;
					x_q  <= req_q.a_den;
				end
			end
			rfa_pkg::ST_QB_RUN: begin
				if (div_res.done) qb_q <= div_res.quot;
			end
			rfa_pkg::ST_TA: begin
				den_q <= prod;
			end
			rfa_pkg::ST_TB: begin
				num_q <= prod;
			end
			rfa_pkg::ST_SUM: begin
				res_q.res_num <= (req_q.req_type == rfa_pkg::OP_ADD) ? num_q + prod
					: num_q - prod;
				res_q.res_den <= den_q;
				res_q.error   <= 1'b0;
			end
			default: begin
			end
		endcase
	end

	assign busy   = (state_q != rfa_pkg::ST_IDLE);
	assign done   = done_q;
	assign result = res_q;

	// Checks
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("done strobe longer than one cycle");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && res_q.error) |-> (res_q.res_num == '0 && res_q.res_den == '0))
		else $error("error word carries nonzero result");

	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_res.done |-> (state_q == rfa_pkg::ST_GCD_RUN ||
			state_q == rfa_pkg::ST_QA_RUN || state_q == rfa_pkg::ST_QB_RUN))
		else $error("divider finished outside a wait state");

	a_divisor_nz: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> (y_q != '0))
		else $error("divider started with zero divisor");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted word did not raise busy");

endmodule
